>>> design/rcdt_pkg.sv
package rcdt_pkg;

  localparam int BaseRows = 13;
  localparam int CtrRows = 26;
  localparam int CtrTables = 9;

  typedef logic [72:0] thr_t;
  typedef logic [71:0] val_t;
  typedef logic [4:0] cnt_t;
  typedef logic [4:0] smp_t;
  typedef logic [3:0] ctr_t;

  function automatic thr_t mk(input logic [24:0] w2, input logic [23:0] w1,
                              input logic [23:0] w0);
    mk = {w2, w1, w0};
  endfunction

  function automatic thr_t base_thr(input logic [3:0] i);
    case (i)
      4'd0: base_thr = mk(25'd9012524, 24'd15192425, 24'd15853829);
      4'd1: base_thr = mk(25'd3172061, 24'd13917703, 24'd5737857);
      4'd2: base_thr = mk(25'd686545, 24'd12076027, 24'd6719412);
      4'd3: base_thr = mk(25'd88089, 24'd15395855, 24'd10985591);
      4'd4: base_thr = mk(25'd6564, 24'd6030263, 24'd1110348);
      4'd5: base_thr = mk(25'd280, 24'd14404062, 24'd4382442);
      4'd6: base_thr = mk(25'd6, 24'd14348844, 24'd14221742);
      4'd7: base_thr = mk(25'd0, 24'd1595710, 24'd8739360);
      4'd8: base_thr = mk(25'd0, 24'd12559, 24'd592817);
      4'd9: base_thr = mk(25'd0, 24'd56, 24'd138767);
      4'd10: base_thr = mk(25'd0, 24'd0, 24'd2372903);
      4'd11: base_thr = mk(25'd0, 24'd0, 24'd3391);
      4'd12: base_thr = mk(25'd0, 24'd0, 24'd2);
      default: base_thr = '0;
    endcase
  endfunction

  function automatic thr_t ctr_thr(input ctr_t t, input logic [4:0] i);
    logic [71:0] r [0:25];
    begin
      for (int k = 0; k < 26; k++) r[k] = '0;
      ctr_thr = '0;
      case (t)
        4'd0: begin
          r = '{{24'd16777215,24'd16777215,24'd16777215},{24'd16777215,24'd16777215,24'd16775011},
                {24'd16777215,24'd16777215,24'd15233552},{24'd16777215,24'd16777179,24'd9470246},
                {24'd16777215,24'd16769045,24'd14522865},{24'd16777215,24'd15739145,24'd1332846},
                {24'd16777211,24'd9066269,24'd6939571},{24'd16777033,24'd4877764,24'd16146876},
                {24'd16772945,24'd10608537,24'd11482579},{24'd16719910,24'd2157349,24'd15627080},
                {24'd16330591,24'd11187431,24'd5168729},{24'd14713668,24'd1162033,24'd6316591},
                {24'd10914222,24'd12454635,24'd9807704},{24'd5862993,24'd4322580,24'd6969512},
                {24'd2063547,24'd15615182,24'd10460625},{24'd446624,24'd5589784,24'd11608487},
                {24'd57305,24'd14619866,24'd1150136},{24'd4270,24'd6168678,24'd5294637},
                {24'd182,24'd11899451,24'd630340},{24'd4,24'd7710946,24'd9837645},
                {24'd0,24'd1038070,24'd15444370},{24'd0,24'd8170,24'd2254351},
                {24'd0,24'd36,24'd7306970},{24'd0,24'd0,24'd1543664},
                {24'd0,24'd0,24'd2205},{24'd0,24'd0,24'd1}};
        end
        4'd1: begin
          r = '{{24'd16777215,24'd16777215,24'd16777215},{24'd16777215,24'd16777215,24'd16775779},
                {24'd16777215,24'd16777215,24'd15734918},{24'd16777215,24'd16777190,24'd8519352},
                {24'd16777215,24'd16771293,24'd13856},{24'd16777215,24'd15997481,24'd2513950},
                {24'd16777212,24'd8884624,24'd4508330},{24'd16777068,24'd12078839,24'd6687720},
                {24'd16773651,24'd5683901,24'd11687263},{24'd16727705,24'd10250903,24'd10929223},
                {24'd16378208,24'd15703768,24'd14490080},{24'd14874072,24'd12477629,24'd13387724},
                {24'd11211574,24'd1456957,24'd7088950},{24'd6165960,24'd8535982,24'd839654},
                {24'd2233207,24'd4266951,24'd2499711},{24'd498901,24'd11986748,24'd6858912},
                {24'd66187,24'd15716961,24'd4844771},{24'd5104,24'd11760568,24'd13330078},
                {24'd226,24'd2761788,24'd7939383},{24'd5,24'd12047547,24'd8851391},
                {24'd0,24'd1378939,24'd9602935},{24'd0,24'd11244,24'd13954839},
                {24'd0,24'd51,24'd16123699},{24'd0,24'd0,24'd2281119},
                {24'd0,24'd0,24'd3377},{24'd0,24'd0,24'd2}};
        end
        4'd2: begin
          r = '{{24'd0,24'd0,24'd0},{24'd16777215,24'd16777215,24'd16776282},
                {24'd16777215,24'd16777215,24'd16075008},{24'd16777215,24'd16777198,24'd3420825},
                {24'd16777215,24'd16772931,24'd10019250},{24'd16777215,24'd16192823,24'd3671359},
                {24'd16777213,24'd5121881,24'd11581530},{24'd16777097,24'd9048345,24'd1478444},
                {24'd16774246,24'd14686656,24'd5022514},{24'd16734531,24'd10422121,24'd13873334},
                {24'd16421480,24'd13122408,24'd1342376},{24'd15025374,24'd2116586,24'd11478387},
                {24'd11502732,24'd199963,24'd13103970},{24'd6473928,24'd12068169,24'd16138360},
                {24'd2412236,24'd14359899,24'd12980950},{24'd556161,24'd16040368,24'd10443848},
                {24'd76284,24'd10717728,24'd11789395},{24'd6088,24'd14022374,24'd14339575},
                {24'd279,24'd5742655,24'd16086714},{24'd7,24'd5294054,24'd11750430},
                {24'd0,24'd1827686,24'd10410941},{24'd0,24'd15442,24'd5669306},
                {24'd0,24'd73,24'd15731965},{24'd0,24'd0,24'd3363395},
                {24'd0,24'd0,24'd5161},{24'd0,24'd0,24'd4}};
        end
        4'd3: begin
          r = '{{24'd0,24'd0,24'd0},{24'd16777215,24'd16777215,24'd16776611},
                {24'd16777215,24'd16777215,24'd16305182},{24'd16777215,24'd16777203,24'd10135410},
                {24'd16777215,24'd16774123,24'd12536703},{24'd16777215,24'd16340196,24'd12544412},
                {24'd16777213,24'd15304752,24'd2987106},{24'd16777120,24'd15575234,24'd1968575},
                {24'd16774748,24'd4787791,24'd7259276},{24'd16740494,24'd15322764,24'd4474492},
                {24'd16460712,24'd7759407,24'd2088210},{24'd15167756,24'd4648416,24'd3058045},
                {24'd11787159,24'd11933600,24'd5835273},{24'd6786249,24'd3272430,24'd4245928},
                {24'd2600713,24'd13079649,24'd9005847},{24'd618734,24'd4683791,24'd16134114},
                {24'd87735,24'd8947395,24'd8925252},{24'd7246,24'd16719176,24'd11997485},
                {24'd344,24'd4503102,24'd9130208},{24'd9,24'd5681958,24'd3044503},
                {24'd0,24'd2417111,24'd8148392},{24'd0,24'd21159,24'd11787304},
                {24'd0,24'd104,24'd16371337},{24'd0,24'd0,24'd4948144},
                {24'd0,24'd0,24'd7869},{24'd0,24'd0,24'd7}};
        end
        4'd4: begin
          r = '{{24'd0,24'd0,24'd0},{24'd16777215,24'd16777215,24'd16776824},
                {24'd16777215,24'd16777215,24'd16460612},{24'd16777215,24'd16777207,24'd6455988},
                {24'd16777215,24'd16774989,24'd2112471},{24'd16777215,24'd16451128,24'd10488461},
                {24'd16777214,24'd6476734,24'd102573},{24'd16777139,24'd14543202,24'd8921074},
                {24'd16775169,24'd7973744,24'd14815034},{24'd16745692,24'd8189814,24'd649095},
                {24'd16496198,24'd10729516,24'd3309815},{24'd15301432,24'd13605636,24'd8529274},
                {24'd12064363,24'd15299019,24'd13921129},{24'd7102243,24'd9426242,24'd528518},
                {24'd2798673,24'd14100379,24'd12355221},{24'd686952,24'd9672592,24'd118565},
                {24'd100692,24'd3354292,24'd12123958},{24'd8606,24'd13729655,24'd8241237},
                {24'd423,24'd5987695,24'd3524427},{24'd11,24'd15016101,24'd4328906},
                {24'd0,24'd3189556,24'd2664037},{24'd0,24'd28929,24'd10235654},
                {24'd0,24'd148,24'd11955907},{24'd0,24'd0,24'd7263424},
                {24'd0,24'd0,24'd11970},{24'd0,24'd0,24'd11}};
        end
        4'd5: begin
          r = '{{24'd0,24'd0,24'd0},{24'd16777215,24'd16777215,24'd16776963},
                {24'd16777215,24'd16777215,24'd16565334},{24'd16777215,24'd16777210,24'd431050},
                {24'd16777215,24'd16775615,24'd14782869},{24'd16777215,24'd16534440,24'd7518157},
                {24'd16777214,24'd12668094,24'd11574123},{24'd16777155,24'd2794598,24'd7322704},
                {24'd16775522,24'd7823380,24'd2944073},{24'd16750212,24'd3442583,24'd13732427},
                {24'd16528222,24'd7064732,24'd14157513},{24'd15426643,24'd11162773,24'd152241},
                {24'd12333897,24'd3899757,24'd7500282},{24'd7421208,24'd2852132,24'd14942011},
                {24'd3006109,24'd3952054,24'd5078665},{24'd761153,24'd6675749,24'd15883187},
                {24'd115318,24'd11991252,24'd4430286},{24'd10199,24'd12375809,24'd13360834},
                {24'd519,24'd7989154,24'd653598},{24'd15,24'd1976374,24'd5873772},
                {24'd0,24'd4199548,24'd11784434},{24'd0,24'd39465,24'd164953},
                {24'd0,24'd210,24'd3429641},{24'd0,24'd0,24'd10638369},
                {24'd0,24'd0,24'd18166},{24'd0,24'd0,24'd17}};
        end
        4'd6: begin
          r = '{{24'd16777215,24'd16777215,24'd16777053},{24'd16777215,24'd16777215,24'd16635733},
                {24'd16777215,24'd16777211,24'd14533128},{24'd16777215,24'd16776068,24'd13176720},
                {24'd16777215,24'd16596867,24'd2818899},{24'd16777215,24'd702139,24'd2158111},
                {24'd16777167,24'd8361981,24'd11462669},{24'd16775817,24'd10427652,24'd6087842},
                {24'd16754133,24'd6628640,24'd8505703},{24'd16557054,24'd9982058,24'd10422601},
                {24'd15543651,24'd13920268,24'd12511946},{24'd12595360,24'd976548,24'd2123600},
                {24'd7742418,24'd13228792,24'd4397967},{24'd3222966,24'd7593824,24'd6273837},
                {24'd841673,24'd12197092,24'd417005},{24'd131792,24'd1022564,24'd12422311},
                {24'd12061,24'd6921901,24'd10390765},{24'd636,24'd433892,24'd15282340},
                {24'd19,24'd2876280,24'd6165299},{24'd0,24'd5517139,24'd9715242},
                {24'd0,24'd53717,24'd14145998},{24'd0,24'd296,24'd7776896},
                {24'd0,24'd0,24'd15546888},{24'd0,24'd0,24'd27509},
                {24'd0,24'd0,24'd27},{24'd0,24'd0,24'd0}};
        end
        4'd7: begin
          r = '{{24'd0,24'd0,24'd0},{24'd16777215,24'd16777215,24'd16777112},
                {24'd16777215,24'd16777215,24'd16682952},{24'd16777215,24'd16777213,24'd2451297},
                {24'd16777215,24'd16776395,24'd5400393},{24'd16777215,24'd16643538,24'd4805989},
                {24'd16777215,24'd4432422,24'd9776448},{24'd16777177,24'd6968663,24'd4142559},
                {24'd16776063,24'd14264369,24'd4909544},{24'd16757527,24'd7823048,24'd1595304},
                {24'd16582953,24'd799962,24'd1788418},{24'd15652740,24'd1238522,24'd3476302},
                {24'd12848401,24'd15485017,24'd9852662},{24'd8065135,24'd9010397,24'd4506077},
                {24'd3449144,24'd8647345,24'd7184768},{24'd928848,24'd9370405,24'd3497225},
                {24'd150302,24'd7802978,24'd13797364},{24'd14232,24'd2903892,24'd14449980},
                {24'd777,24'd408185,24'd5570114},{24'd24,24'd4337109,24'd5205347},
                {24'd0,24'd7232101,24'd2056411},{24'd0,24'd72956,24'd2049618},
                {24'd0,24'd417,24'd3225336},{24'd0,24'd1,24'd5892529},
                {24'd0,24'd0,24'd41566},{24'd0,24'd0,24'd43}};
        end
        4'd8: begin
          r = '{{24'd0,24'd0,24'd0},{24'd16777215,24'd16777215,24'd16777149},
                {24'd16777215,24'd16777215,24'd16714551},{24'd16777215,24'd16777214,24'd571856},
                {24'd16777215,24'd16776630,24'd3641516},{24'd16777215,24'd16678351,24'd2749011},
                {24'd16777215,24'd7318016,24'd12418468},{24'd16777185,24'd6242755,24'd14064432},
                {24'd16776268,24'd13271651,24'd8965282},{24'd16760458,24'd8383848,24'd4298097},
                {24'd16606162,24'd5963861,24'd1213664},{24'd15754207,24'd11955561,24'd14308639},
                {24'd13092722,24'd6657257,24'd16408895},{24'd8388608,24'd0,24'd0},
                {24'd3684493,24'd10119958,24'd368321},{24'd1023008,24'd4821654,24'd2468577},
                {24'd171053,24'd10813354,24'd15563552},{24'd16757,24'd8393367,24'd12479119},
                {24'd947,24'd3505564,24'd7811934},{24'd30,24'd10534460,24'd2712784},
                {24'd0,24'd9459199,24'd4358748},{24'd0,24'd98864,24'd14028205},
                {24'd0,24'd585,24'd13135700},{24'd0,24'd1,24'd16205360},
                {24'd0,24'd0,24'd62665},{24'd0,24'd0,24'd67}};
        end
        default: begin
        end
      endcase
      if (i < 5'(CtrRows)) begin
        ctr_thr = {1'b0, r[i]};
        if (i == 5'd0 && t >= 4'd2 && t != 4'd6) ctr_thr = {1'b1, 72'd0};
      end
    end
  endfunction

endpackage

>>> design/rcdt_count.sv
module rcdt_count (
  input  logic          func,
  input  rcdt_pkg::val_t v,
  input  rcdt_pkg::ctr_t center,
  output rcdt_pkg::smp_t sample
);
  import rcdt_pkg::*;

  ctr_t tsel;
  cnt_t zb;
  cnt_t zc;

  assign tsel = (center > 4'd8) ? 4'(5'd16 - {1'b0, center}) : center;

  always_comb begin
    zb = '0;
    zc = '0;
    for (int i = 0; i < BaseRows; i++) begin
      zb = zb + cnt_t'(base_thr(4'(i)) > {1'b0, v});
    end
    for (int i = 0; i < CtrRows; i++) begin
      zc = zc + cnt_t'(ctr_thr(tsel, 5'(i)) > {1'b0, v});
    end
    if (!func) begin
      sample = zb;
    end else if (center > 4'd8) begin
      sample = 5'd14 - zc;
    end else begin
      sample = zc - 5'd13;
    end
  end
endmodule

>>> design/rcdt_gaussian_base_sampler.sv
// Reverse-CDT discrete Gaussian base sampler.
// Input channel: in_valid/in_stall with in_func, in_random_low, in_random_high
// and in_center; a beat is taken when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall with out_sample, a 5-bit two's
// complement value; the receiver holds out_stall high to hold the beat.
// Each beat is registered at the input, compared against the selected ROM
// table combinationally, and registered again at the output, which drives
// out_valid.
// Throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls, the output beat holds and the input register
// fills; in_stall rises only when both registers hold beats.
// A synchronous active-low reset empties both registers; no table state
// needs clearing.
module rcdt_gaussian_base_sampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [63:0] in_random_low,
  input  logic [7:0]  in_random_high,
  input  logic [3:0]  in_center,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [4:0] out_sample
);
  import rcdt_pkg::*;

  logic  a_vld_r;
  logic  a_func_r;
  val_t  a_v_r;
  ctr_t  a_ctr_r;
  logic  b_vld_r;
  smp_t  b_smp_r;
  smp_t  smp_nxt;
  logic  b_take;
  logic  a_take;

  rcdt_count u_count (
    .func   (a_func_r),
    .v      (a_v_r),
    .center (a_ctr_r),
    .sample (smp_nxt)
  );

  assign b_take   = a_vld_r && (!b_vld_r || !out_stall);
  assign in_stall = a_vld_r && !b_take;
  assign a_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_take) begin
        a_vld_r <= 1'b1;
      end else if (b_take) begin
        a_vld_r <= 1'b0;
      end
      if (b_take) begin
        b_vld_r <= 1'b1;
      end else if (!out_stall) begin
        b_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      a_func_r <= in_func;
      a_v_r    <= {in_random_high, in_random_low};
      a_ctr_r  <= in_center;
    end
    if (b_take) begin
      b_smp_r <= smp_nxt;
    end
  end

  assign out_valid  = b_vld_r;
  assign out_sample = b_smp_r;

`ifndef NO_ASSERTIONS
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (a_vld_r && b_vld_r && out_stall)) else $error("stall while not full");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("output beat lost");
  a_mode0: assert property (@(posedge clk) disable iff (!rst_n)
    (b_take && !a_func_r) |-> (smp_nxt <= 5'd13)) else $error("mode 0 count out of range");
`endif
endmodule
